@@ hw/rtl/ede_pkg.sv @@
// Shared definitions for the edit distance engine: operation codes, fixed field
// widths, default sizes and the control struct that travels along the cell chain.
// No dependencies.
package ede_pkg;

  localparam int MAX_LEN_DEF   = 64;
  localparam int CHAR_BITS_DEF = 16;

  // Fixed widths of the transaction fields.
  localparam int OP_W   = 2;
  localparam int CH_W   = 16;
  localparam int DIST_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  // Control part of a token moving down the column.
  // valid marks a token; fin marks a finish token that collects the distance.
  typedef struct packed {
    logic valid;
    logic fin;
  } tok_ctl_t;

endpackage

@@ hw/rtl/ede_in_if.sv @@
// Input channel of the edit distance engine: valid/ready handshake with op and ch.
// Depends on ede_pkg for the field widths.
interface ede_in_if;
  logic                      valid;
  logic                      ready;
  logic [ede_pkg::OP_W-1:0]  op;
  logic [ede_pkg::CH_W-1:0]  ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

@@ hw/rtl/ede_out_if.sv @@
// Result channel of the edit distance engine: valid/ready handshake with the
// distance and the too_long flag. Depends on ede_pkg for the field widths.
interface ede_out_if;
  logic                        valid;
  logic                        ready;
  logic [ede_pkg::DIST_W-1:0]  distance;
  logic                        too_long;

  modport source (output valid, output distance, output too_long, input ready);
  modport sink   (input valid, input distance, input too_long, output ready);
endinterface

@@ hw/rtl/ede_cell.sv @@
// One cell of the dynamic-programming column: holds one reference character and
// the column entry for that prefix length. Depends on ede_pkg.
module ede_cell #(
  parameter int IDX = 1,
  parameter int DW  = 7,
  parameter int CW  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              active,
  input  logic              wr_en,
  input  logic [CW-1:0]     wr_ch,
  input  ede_pkg::tok_ctl_t in_ctl,
  input  logic [CW-1:0]     in_ch,
  input  logic [DW-1:0]     in_left,
  input  logic [DW-1:0]     in_diag,
  output ede_pkg::tok_ctl_t out_ctl,
  output logic [CW-1:0]     out_ch,
  output logic [DW-1:0]     out_left,
  output logic [DW-1:0]     out_diag
);

  logic [CW-1:0]     ch_r;
  logic [DW-1:0]     d_r;
  ede_pkg::tok_ctl_t out_ctl_r;
  logic [CW-1:0]     out_ch_r;
  logic [DW-1:0]     out_left_r;
  logic [DW-1:0]     out_diag_r;

  logic [DW:0]   above_inc;
  logic [DW:0]   left_inc;
  logic [DW:0]   diag_inc;
  logic [DW:0]   min_ab;
  logic [DW:0]   min_all;
  logic [DW-1:0] new_d;

  // Cost of reaching this entry by deletion, insertion or match/substitution.
  always_comb begin
    above_inc = {1'b0, d_r} + {{DW{1'b0}}, 1'b1};
    left_inc  = {1'b0, in_left} + {{DW{1'b0}}, 1'b1};
    diag_inc  = {1'b0, in_diag} + {{DW{1'b0}}, (ch_r != in_ch)};
    min_ab    = (above_inc < left_inc) ? above_inc : left_inc;
    min_all   = (min_ab < diag_inc) ? min_ab : diag_inc;
    new_d     = min_all[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else begin
      out_ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    out_ch_r   <= in_ch;
    out_diag_r <= d_r;
    // Inactive cells lie past the reference end and just forward the token.
    if (active) begin
      out_left_r <= in_ctl.fin ? d_r : new_d;
    end else begin
      out_left_r <= in_left;
    end
    if (wr_en) begin
      ch_r <= wr_ch;
      d_r  <= DW'(IDX);
    end else if (in_ctl.valid && !in_ctl.fin && active) begin
      d_r <= new_d;
    end
  end

  assign out_ctl  = out_ctl_r;
  assign out_ch   = out_ch_r;
  assign out_left = out_left_r;
  assign out_diag = out_diag_r;

endmodule

@@ hw/rtl/edit_distance_engine.sv @@
// Levenshtein edit distance engine built as a systolic column of MAX_LEN cells.
// Append and query transactions are taken one per cycle while no finish is outstanding; a
// query character walks the cell chain one cell per cycle, updating each active cell's entry.
// A finish transaction passes the injection register and every cell register, and its result
// is then registered at the output; no input is taken from the finish until that result is taken.
// Synchronous reset clears lengths, the overflow flag and all token valids; no clearing pass.
module edit_distance_engine #(
  parameter int MAX_LEN   = ede_pkg::MAX_LEN_DEF,
  parameter int CHAR_BITS = ede_pkg::CHAR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ede_in_if.sink    in_if,
  ede_out_if.source out_if
);

  localparam int DW = $clog2(MAX_LEN + 1);
  localparam int CW = (CHAR_BITS < ede_pkg::CH_W) ? CHAR_BITS : ede_pkg::CH_W;

  logic [DW-1:0] ref_len_r, ref_len_nxt;
  logic [DW-1:0] qlen_r, qlen_nxt;
  logic          ovf_r, ovf_nxt;
  logic          busy_r, busy_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [ede_pkg::DIST_W-1:0] out_dist_r;
  logic          out_tl_r;

  ede_pkg::tok_ctl_t inj_ctl_r, inj_ctl_nxt;
  logic [CW-1:0]     inj_ch_r;
  logic [DW-1:0]     inj_left_r, inj_left_nxt;
  logic [DW-1:0]     inj_diag_r;

  ede_pkg::tok_ctl_t tok_ctl  [0:MAX_LEN];
  logic [CW-1:0]     tok_ch   [0:MAX_LEN];
  logic [DW-1:0]     tok_left [0:MAX_LEN];
  logic [DW-1:0]     tok_diag [0:MAX_LEN];

  logic          in_fire;
  logic          out_fire;
  logic          app_fire;
  logic [CW-1:0] in_chr;
  logic          chain_done;

  assign in_if.ready = !busy_r;
  assign in_fire     = in_if.valid && !busy_r;
  assign out_fire    = out_valid_r && out_if.ready;
  assign in_chr      = CW'(in_if.ch);
  assign chain_done  = tok_ctl[MAX_LEN].valid && tok_ctl[MAX_LEN].fin;

  // Appends are dropped once the query has started; the target cell is decoded per cell.
  assign app_fire = in_fire && (in_if.op == ede_pkg::OP_APPEND) && (qlen_r == '0) &&
                    (ref_len_r != DW'(MAX_LEN));

  always_comb begin
    ref_len_nxt   = ref_len_r;
    qlen_nxt      = qlen_r;
    ovf_nxt       = ovf_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    inj_ctl_nxt   = '0;
    inj_left_nxt  = qlen_r;
    if (in_fire) begin
      unique case (in_if.op)
        ede_pkg::OP_APPEND: begin
          if (qlen_r == '0) begin
            if (ref_len_r == DW'(MAX_LEN)) begin
              ovf_nxt = 1'b1;
            end else begin
              ref_len_nxt = ref_len_r + DW'(1);
            end
          end
        end
        ede_pkg::OP_QUERY: begin
          if (qlen_r == DW'(MAX_LEN)) begin
            ovf_nxt = 1'b1;
          end else begin
            qlen_nxt          = qlen_r + DW'(1);
            inj_ctl_nxt.valid = 1'b1;
            inj_left_nxt      = qlen_r + DW'(1);
          end
        end
        ede_pkg::OP_FINISH: begin
          busy_nxt          = 1'b1;
          inj_ctl_nxt.valid = 1'b1;
          inj_ctl_nxt.fin   = 1'b1;
        end
        default: begin
        end
      endcase
    end
    // The finish token leaving the chain carries the distance; lengths and overflow clear then.
    if (chain_done) begin
      out_valid_nxt = 1'b1;
      ref_len_nxt   = '0;
      qlen_nxt      = '0;
      ovf_nxt       = 1'b0;
    end
    if (out_fire) begin
      out_valid_nxt = 1'b0;
      busy_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r   <= '0;
      qlen_r      <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      inj_ctl_r   <= '0;
    end else begin
      ref_len_r   <= ref_len_nxt;
      qlen_r      <= qlen_nxt;
      ovf_r       <= ovf_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      inj_ctl_r   <= inj_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inj_ch_r   <= in_chr;
    inj_left_r <= inj_left_nxt;
    inj_diag_r <= qlen_r;
    if (chain_done) begin
      out_dist_r <= ede_pkg::DIST_W'(tok_left[MAX_LEN]);
      out_tl_r   <= ovf_r;
    end
  end

  assign tok_ctl[0]  = inj_ctl_r;
  assign tok_ch[0]   = inj_ch_r;
  assign tok_left[0] = inj_left_r;
  assign tok_diag[0] = inj_diag_r;

  for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
    ede_cell #(
      .IDX (g),
      .DW  (DW),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .active   (ref_len_r >= DW'(g)),
      .wr_en    (app_fire && (ref_len_r == DW'(g - 1))),
      .wr_ch    (in_chr),
      .in_ctl   (tok_ctl[g-1]),
      .in_ch    (tok_ch[g-1]),
      .in_left  (tok_left[g-1]),
      .in_diag  (tok_diag[g-1]),
      .out_ctl  (tok_ctl[g]),
      .out_ch   (tok_ch[g]),
      .out_left (tok_left[g]),
      .out_diag (tok_diag[g])
    );
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.distance = out_dist_r;
  assign out_if.too_long = out_tl_r;

  // A result can only be pending while a finish is outstanding.
  a_out_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r)
    else $error("result valid without an outstanding finish");

  // An accepted finish launches a finish token into the column on the next cycle.
  a_finish_injects: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_if.op == ede_pkg::OP_FINISH)) |=> (inj_ctl_r.valid && inj_ctl_r.fin))
    else $error("finish accepted but no finish token injected");

  // Neither string length counter may run past the column size.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ref_len_r <= DW'(MAX_LEN)) && (qlen_r <= DW'(MAX_LEN)))
    else $error("length counter beyond MAX_LEN");

  // The finish token only exits the chain while the block is waiting for it.
  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain_done |-> (busy_r && !out_valid_r))
    else $error("finish token left the column unexpectedly");

endmodule

@@ tb/edit_distance_engine_test.sv @@
// Self-checking testbench for edit_distance_engine: directed and random append, query
// and finish transactions are checked against an in-bench Levenshtein predictor.
// Depends on ede_pkg, ede_in_if and ede_out_if.
module edit_distance_engine_test;

  localparam int MAX_LEN = ede_pkg::MAX_LEN_DEF;
  localparam logic [ede_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [ede_pkg::DIST_W-1:0] distance;
    logic                       too_long;
  } distance_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ede_in_if  in_ch ();
  ede_out_if out_ch ();

  edit_distance_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: reference text and the dynamic-programming column.
  logic [ede_pkg::CH_W-1:0] ref_text [MAX_LEN];
  int                       dp_col   [MAX_LEN+1];
  int                       ref_count;
  int                       query_count;
  logic                     length_overflow;

  distance_result_t pending_distances [$];
  int               error_count = 0;
  int               items_sent = 0;
  int               in_idle_pct = 0;
  int               out_idle_pct = 0;

  function automatic void clear_predictor();
    for (int i = 0; i <= MAX_LEN; i++) dp_col[i] = 0;
    for (int i = 0; i < MAX_LEN; i++) ref_text[i] = '0;
    ref_count       = 0;
    query_count     = 0;
    length_overflow = 1'b0;
  endfunction

  function automatic void predict_distance(input logic [ede_pkg::OP_W-1:0] op_code,
                                           input logic [ede_pkg::CH_W-1:0] ch);
    int diag;
    int above_old;
    int best;
    distance_result_t res;
    case (op_code)
      ede_pkg::OP_APPEND: begin
        // Reference characters arriving after the query has started are dropped.
        if (query_count == 0) begin
          if (ref_count >= MAX_LEN) begin
            length_overflow = 1'b1;
          end else begin
            ref_text[ref_count]  = ch;
            dp_col[ref_count+1]  = ref_count + 1;
            ref_count++;
          end
        end
      end
      ede_pkg::OP_QUERY: begin
        if (query_count >= MAX_LEN) begin
          length_overflow = 1'b1;
        end else begin
          query_count++;
          diag      = dp_col[0];
          dp_col[0] = query_count;
          for (int y = 1; y <= ref_count; y++) begin
            above_old = dp_col[y];
            best = above_old + 1;
            if (dp_col[y-1] + 1 < best) best = dp_col[y-1] + 1;
            if (diag + ((ref_text[y-1] == ch) ? 0 : 1) < best)
              best = diag + ((ref_text[y-1] == ch) ? 0 : 1);
            dp_col[y] = best;
            diag = above_old;
          end
        end
      end
      ede_pkg::OP_FINISH: begin
        res.distance = dp_col[ref_count][ede_pkg::DIST_W-1:0];
        res.too_long = length_overflow;
        pending_distances.push_back(res);
        clear_predictor();
      end
      default: ;
    endcase
  endfunction

  // Sends one transaction; valid stays high into the next call unless an idle gap is taken.
  task automatic send_item(input logic [ede_pkg::OP_W-1:0] op_code,
                           input logic [ede_pkg::CH_W-1:0] ch);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op_code;
    in_ch.ch    <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_distance(op_code, ch);
    items_sent++;
  endtask

  task automatic wait_drained();
    while (pending_distances.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    distance_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_distances.size() == 0) begin
        $error("unexpected result: distance %0d, too_long %0b",
               out_ch.distance, out_ch.too_long);
        error_count++;
      end else begin
        want = pending_distances.pop_front();
        if (out_ch.distance !== want.distance) begin
          $error("distance: expected %0d, actual %0d", want.distance, out_ch.distance);
          error_count++;
        end
        if (out_ch.too_long !== want.too_long) begin
          $error("too_long: expected %0b, actual %0b", want.too_long, out_ch.too_long);
          error_count++;
        end
      end
    end
  end

  // Characters are mostly drawn from a narrow alphabet so that matches are common.
  function automatic logic [ede_pkg::CH_W-1:0] random_char(
      input logic [ede_pkg::CH_W-1:0] base);
    if ($urandom_range(99) < 60) return base + ede_pkg::CH_W'($urandom_range(3, 0));
    return ede_pkg::CH_W'($urandom_range(65535, 0));
  endfunction

  task automatic maybe_noise(input logic [ede_pkg::CH_W-1:0] base);
    if ($urandom_range(99) < 4)
      send_item(($urandom_range(1, 0) != 0) ? OP_UNUSED : ede_pkg::OP_APPEND,
                random_char(base));
  endtask

  task automatic test_basic_cases();
    // Both strings empty.
    send_item(ede_pkg::OP_FINISH, 16'hFFFF);
    // Empty query against a two-character reference at the character extremes.
    send_item(ede_pkg::OP_APPEND, 16'h0000);
    send_item(ede_pkg::OP_APPEND, 16'hFFFF);
    send_item(ede_pkg::OP_FINISH, 16'h0000);
    // Empty reference.
    send_item(ede_pkg::OP_QUERY, 16'hFFFF);
    send_item(ede_pkg::OP_QUERY, 16'h0000);
    send_item(ede_pkg::OP_QUERY, 16'h1234);
    send_item(ede_pkg::OP_FINISH, 16'h5555);
    // Identical strings.
    send_item(ede_pkg::OP_APPEND, 16'hFFFF);
    send_item(ede_pkg::OP_APPEND, 16'h0000);
    send_item(ede_pkg::OP_QUERY, 16'hFFFF);
    send_item(ede_pkg::OP_QUERY, 16'h0000);
    send_item(ede_pkg::OP_FINISH, 16'hAAAA);
    // Substitution, an unused op code and a reference character after the query.
    send_item(ede_pkg::OP_APPEND, 16'h0041);
    send_item(ede_pkg::OP_APPEND, 16'h0042);
    send_item(ede_pkg::OP_QUERY, 16'h0042);
    send_item(OP_UNUSED, 16'h0041);
    send_item(ede_pkg::OP_APPEND, 16'h0043);
    send_item(ede_pkg::OP_QUERY, 16'h0041);
    send_item(ede_pkg::OP_FINISH, 16'h0000);
  endtask

  task automatic test_length_limits();
    // Reference one character past the limit.
    for (int i = 0; i <= MAX_LEN; i++) send_item(ede_pkg::OP_APPEND, ede_pkg::CH_W'(i));
    send_item(ede_pkg::OP_QUERY, 16'h0003);
    send_item(ede_pkg::OP_FINISH, 16'h0000);
    // Query one character past the limit.
    send_item(ede_pkg::OP_APPEND, 16'h0001);
    send_item(ede_pkg::OP_APPEND, 16'h0002);
    send_item(ede_pkg::OP_APPEND, 16'h0003);
    for (int i = 0; i <= MAX_LEN; i++) send_item(ede_pkg::OP_QUERY, ede_pkg::CH_W'(i % 5));
    send_item(ede_pkg::OP_FINISH, 16'h0000);
    // Hold off the sender until both distances are back.
    in_ch.valid <= 1'b0;
    wait_drained();
  endtask

  task automatic run_random_session();
    int ref_n;
    int qry_n;
    logic [ede_pkg::CH_W-1:0] base;
    logic [ede_pkg::CH_W-1:0] ref_seq [$];
    logic [ede_pkg::CH_W-1:0] c;
    base = ede_pkg::CH_W'($urandom_range(65535, 0));
    if ($urandom_range(99) < 10) begin
      // Arbitrary order of operations.
      repeat ($urandom_range(20, 0))
        send_item(ede_pkg::OP_W'($urandom_range(3, 0)), random_char(base));
    end else begin
      ref_n = ($urandom_range(99) < 8) ? $urandom_range(70, 60) : $urandom_range(12, 0);
      qry_n = ($urandom_range(99) < 8) ? $urandom_range(70, 60) : $urandom_range(12, 0);
      for (int i = 0; i < ref_n; i++) begin
        c = random_char(base);
        ref_seq.push_back(c);
        send_item(ede_pkg::OP_APPEND, c);
        maybe_noise(base);
      end
      for (int i = 0; i < qry_n; i++) begin
        if (i < ref_seq.size() && $urandom_range(99) < 50) c = ref_seq[i];
        else c = random_char(base);
        send_item(ede_pkg::OP_QUERY, c);
        maybe_noise(base);
      end
    end
    send_item(ede_pkg::OP_FINISH, ede_pkg::CH_W'($urandom_range(65535, 0)));
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct, input int n_items);
    int start;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    start = items_sent;
    while (items_sent - start < n_items) run_random_session();
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.op     = ede_pkg::OP_APPEND;
    in_ch.ch     = '0;
    clear_predictor();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 28;
    out_idle_pct = 55;
    test_basic_cases();
    test_length_limits();
    test_random_traffic(28, 55, 700);
    test_random_traffic(55, 28, 700);
    test_random_traffic(0, 0, 600);

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (MAX_LEN + 10) @(posedge clk);
    if (pending_distances.size() != 0) begin
      $error("%0d expected results never arrived", pending_distances.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("edit_distance_engine_test: clean");
    end else begin
      $display("edit_distance_engine_test: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("edit_distance_engine_test: errors");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ede_pkg.sv
hw/rtl/ede_in_if.sv
hw/rtl/ede_out_if.sv
hw/rtl/ede_cell.sv
hw/rtl/edit_distance_engine.sv
tb/edit_distance_engine_test.sv
